// File: sv/lobs_pkg.sv
// Package for the order book store: field structs, op and status codes, FSM states.
// No dependencies.
package lobs_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_CANCEL = 3'd1,
      OP_UPDATE = 3'd2,
      OP_FIND = 3'd3,
      OP_BEST_BUY = 3'd4,
      OP_BEST_SELL = 3'd5,
      OP_UNUSED_6 = 3'd6,
      OP_UNUSED_7 = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] ord_id;
      logic        side;
      logic [31:0] limit_px;
      logic [31:0] qty_orig;
      logic [31:0] qty_left;
      logic [31:0] seq_num;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [31:0] held_id;
      logic        held_side;
      logic [31:0] held_price;
      logic [31:0] held_original;
      logic [31:0] held_remaining;
      logic [31:0] held_sequence;
   } rsp_type;

   typedef struct packed {
      logic        side;
      logic [31:0] id;
      logic [31:0] price;
      logic [31:0] original;
      logic [31:0] remaining;
      logic [31:0] seq_num;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_DONE
   } state_type;

endpackage

// File: sv/lobs_rank.sv
// Price-time priority comparator shared by every step of the best-order scan.
// Depends on lobs_pkg.
module lobs_rank
   import lobs_pkg::*;
(
   input  entry_type cand,
   input  entry_type best,
   input  logic      sell,
   output logic      ahead
);

   // rank by price, then earlier sequence, then smaller id
   always_comb begin
      if (cand.price != best.price) begin
         ahead = sell ? (cand.price < best.price) : (cand.price > best.price);
      end else if (cand.seq_num != best.seq_num) begin
         ahead = cand.seq_num < best.seq_num;
      end else begin
         ahead = cand.id < best.id;
      end
   end

endmodule

// File: sv/limit_order_book_store_unit.sv
// Order book store top level: entry memory, scan sequencer, result register.
// Depends on lobs_pkg and lobs_rank.
// Every op passes through S_SCAN, S_READ and S_DONE before the strobe (unused op code: S_DONE only).
// A new word is taken only in S_IDLE, once the last one is done (busy is low); the
// one-entry-per-cycle memory scan takes most of the time per word.
// Reset clears all valid bits at once; the receiver cannot stall the result.
module limit_order_book_store_unit
   import lobs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   entry_type mem [CAPACITY];
   logic [CAPACITY-1:0] valid_ff, valid_in;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   entry_type best_ff, best_in;
   entry_type rd_ff;
   logic rd_ok_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic wr_en;
   logic [SLOT_W-1:0] wr_slot;
   entry_type wr_data;
   logic [SLOT_W-1:0] rd_slot;
   logic ahead, bad_add, is_best, sell;

   // read one entry per cycle, registered
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_slot] <= wr_data;
      rd_ff <= mem[rd_slot];
      rd_ok_ff <= valid_ff[rd_slot];
   end

   lobs_rank u_rank (.cand(rd_ff), .best(best_ff), .sell(sell), .ahead(ahead));

   assign sell = (req_ff.op == OP_BEST_SELL);
   assign is_best = (req_ff.op == OP_BEST_BUY) || sell;
   assign bad_add = (req_ff.ord_id == '0) || (req_ff.limit_px == '0)
      || (req_ff.qty_orig == '0) || (req_ff.qty_left == '0)
      || (req_ff.qty_left > req_ff.qty_orig)
      || (req_ff.seq_num == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      hit_slot_ff <= hit_slot_in;
      free_ff <= free_in;
      free_slot_ff <= free_slot_in;
      best_ff <= best_in;
      rsp_ff <= rsp_in;
   end

   // sequencer: issue reads 0..CAPACITY-1, examine each in the cycle after its read
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hit_slot_in = hit_slot_ff;
      free_in = free_ff;
      free_slot_in = free_slot_ff;
      best_in = best_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en = 1'b0;
      wr_slot = hit_slot_ff;
      wr_data = rd_ff;
      rd_slot = idx_ff[SLOT_W-1:0];
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               rsp_in = '0;
               if (req_data.op inside {OP_UNUSED_6, OP_UNUSED_7}) begin
                  rsp_in.status = ST_INVALID;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // examine entry idx-1 read last cycle
            if (idx_ff != '0) begin
               if (rd_ok_ff) begin
                  if (is_best) begin
                     if (rd_ff.side == sell && (!hit_ff || ahead)) begin
                        hit_in = 1'b1;
                        best_in = rd_ff;
                     end
                  end else if (!hit_ff && rd_ff.id == req_ff.ord_id) begin
                     hit_in = 1'b1;
                     hit_slot_in = SLOT_W'(idx_ff - 1'b1);
                     best_in = rd_ff;
                  end
               end else if (!free_ff) begin
                  free_in = 1'b1;
                  free_slot_in = SLOT_W'(idx_ff - 1'b1);
               end
            end
            if (idx_ff == COUNT_W'(CAPACITY)) state_in = S_READ;
            idx_in = idx_ff + 1'b1;
         end
         S_READ: begin
            // settle status and commit any store change
            state_in = S_DONE;
            rsp_in = '0;
            case (req_ff.op)
               OP_ADD: begin
                  if (bad_add) rsp_in.status = ST_INVALID;
                  else if (hit_ff) rsp_in.status = ST_DUPLICATE;
                  else if (!free_ff) rsp_in.status = ST_FULL;
                  else begin
                     wr_en = 1'b1;
                     wr_slot = free_slot_ff;
                     wr_data.side = req_ff.side;
                     wr_data.id = req_ff.ord_id;
                     wr_data.price = req_ff.limit_px;
                     wr_data.original = req_ff.qty_orig;
                     wr_data.remaining = req_ff.qty_left;
                     wr_data.seq_num = req_ff.seq_num;
                     valid_in[free_slot_ff] = 1'b1;
                  end
               end
               OP_CANCEL: begin
                  if (!hit_ff) rsp_in.status = ST_NOT_FOUND;
                  else valid_in[hit_slot_ff] = 1'b0;
               end
               OP_UPDATE: begin
                  if (req_ff.seq_num == '0) rsp_in.status = ST_INVALID;
                  else if (!hit_ff) rsp_in.status = ST_NOT_FOUND;
                  else begin
                     wr_en = 1'b1;
                     wr_data = best_ff;
                     wr_data.seq_num = req_ff.seq_num;
                  end
               end
               default: begin
                  if (!hit_ff) rsp_in.status = ST_NOT_FOUND;
                  else begin
                     rsp_in.status = ST_OK;
                     rsp_in.found = 1'b1;
                     rsp_in.held_id = best_ff.id;
                     rsp_in.held_side = best_ff.side;
                     rsp_in.held_price = best_ff.price;
                     rsp_in.held_original = best_ff.original;
                     rsp_in.held_remaining = best_ff.remaining;
                     rsp_in.held_sequence = best_ff.seq_num;
                  end
               end
            endcase
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
